@@ sv/ule_pkg.sv @@
// ----------------------------------------------------------------------------
// ule_pkg: shared types and codes for the unordered list engine
// Holds the action codes and the control bundle that fans out to every cell.
// ----------------------------------------------------------------------------
package ule_pkg;

    // Width of one stored element.
    localparam int unsigned ValW = 32;

    // Action codes carried in the input beat.
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // Control broadcast from the top level to each cell.
    typedef struct packed {
        logic            ins_en;  // shift every cell one place back
        logic            rem_en;  // close the gap behind the first match
        logic [ValW-1:0] key;     // value to insert or to match
    } ule_ctrl_t;

endpackage

@@ sv/ule_cell.sv @@
// ----------------------------------------------------------------------------
// ule_cell: one slot of the list
// Holds one element, compares it with the key and takes the value of its
// front or back neighbor when the list shifts.
// ----------------------------------------------------------------------------
module ule_cell import ule_pkg::*; (
    input  logic            aclk,
    input  ule_ctrl_t       ctrl,
    input  logic            live,      // slot lies below the current count
    input  logic [ValW-1:0] front_val, // neighbor nearer the front
    input  logic [ValW-1:0] back_val,  // neighbor farther from the front
    input  logic            seen_in,   // a match was found nearer the front
    output logic [ValW-1:0] val,
    output logic            seen_out
);

    logic [ValW-1:0] val_reg;
    logic [ValW-1:0] val_next;

    // A live slot that equals the key joins the match prefix.
    assign seen_out = seen_in | (live && (val_reg == ctrl.key));
    assign val      = val_reg;

    // Insert moves everything back; remove pulls the tail forward from the match on.
    always_comb begin
        priority if (ctrl.ins_en) begin
            val_next = front_val;
        end else if (ctrl.rem_en && seen_out) begin
            val_next = back_val;
        end else begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

@@ sv/unordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// unordered_list_engine: fixed-capacity unordered list of signed values
// Insert at the front, remove the first match, read by position. The list
// lives in a row of cells that shift toward or away from the front together.
// ----------------------------------------------------------------------------
//  Channel   Dir   Payload (tdata, low bit first)
//  s_        in    action[1:0], value[33:2], position[37:34], zero pad
//  m_        out   ok[0], read_value[32:1], count[37:33], empty_res[38], zero pad
//
// Each beat is handled in the cycle it is accepted: all cells compare and shift
// at once, and the result lands in the output register at the end of that cycle.
// A new beat is taken while the output register is empty or being drained.
// Reset clears the count and the output valid; cell contents are not cleared.
// When the result is stalled, the input is held off until it leaves.
// ----------------------------------------------------------------------------
module unordered_list_engine import ule_pkg::*; #(
    parameter int unsigned DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // action[1:0], value[33:2], position[37:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // ok, read_value, count, empty_res
);

    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam int unsigned RdN  = (DEPTH < 16) ? DEPTH : 16;

    // Input fields.
    logic [1:0]      in_action;
    logic [ValW-1:0] in_value;
    logic [3:0]      in_position;
    logic            s_fire;

    assign in_action   = s_tdata[1:0];
    assign in_value    = s_tdata[33:2];
    assign in_position = s_tdata[37:34];
    assign s_fire      = s_tvalid && s_tready;

    // Count and result registers.
    logic [CntW-1:0] count_reg, count_next;
    logic            m_valid_reg, m_valid_next;
    logic            res_ok_reg, res_ok_next;
    logic [ValW-1:0] res_rd_reg, res_rd_next;
    logic [4:0]      res_cnt_reg, res_cnt_next;
    logic            res_empty_reg, res_empty_next;

    // Cell row wiring.
    ule_ctrl_t       ctrl;
    logic [ValW-1:0] cell_val [DEPTH];
    logic            seen [DEPTH+1];
    logic            live [DEPTH];
    logic            full;
    logic            found;
    logic            rd_ok;
    logic [ValW-1:0] rd_val;
    logic [CntW+4:0] cnt_wide;

    assign s_tready = !m_valid_reg || m_tready;
    assign full     = (count_reg == CntW'(DEPTH));
    assign found    = seen[DEPTH];
    assign seen[0]  = 1'b0;

    // Broadcast control to every cell.
    always_comb begin
        ctrl.key    = in_value;
        ctrl.ins_en = s_fire && (in_action == ACT_INSERT) && !full;
        ctrl.rem_en = s_fire && (in_action == ACT_REMOVE);
    end

    // The row of cells; the front cell takes the key, the last cell keeps its own value.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ValW-1:0] front_v;
        logic [ValW-1:0] back_v;

        assign live[i] = (CntW'(i) < count_reg);

        if (i == 0) begin : g_front
            assign front_v = in_value;
        end else begin : g_mid
            assign front_v = cell_val[i-1];
        end

        if (i == DEPTH - 1) begin : g_back
            assign back_v = cell_val[i];
        end else begin : g_inner
            assign back_v = cell_val[i+1];
        end

        ule_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .live      (live[i]),
            .front_val (front_v),
            .back_val  (back_v),
            .seen_in   (seen[i]),
            .val       (cell_val[i]),
            .seen_out  (seen[i+1])
        );
    end

    // Read port over the slots that a position can reach.
    always_comb begin
        rd_val = '0;
        rd_ok  = 1'b0;
        for (int i = 0; i < RdN; i++) begin
            if (in_position == 4'(i)) begin
                rd_val = cell_val[i];
                rd_ok  = live[i];
            end
        end
    end

    // Next count and next result.
    always_comb begin
        count_next  = count_reg;
        res_ok_next = 1'b0;
        res_rd_next = '0;
        unique case (in_action)
            ACT_INSERT: begin
                res_ok_next = !full;
                if (!full) begin
                    count_next = count_reg + CntW'(1);
                end
            end
            ACT_REMOVE: begin
                res_ok_next = found;
                if (found) begin
                    count_next = count_reg - CntW'(1);
                end
            end
            ACT_READ: begin
                res_ok_next = rd_ok;
                if (rd_ok) begin
                    res_rd_next = rd_val;
                end
            end
            default: begin
                res_ok_next = 1'b0;
            end
        endcase
        cnt_wide       = (CntW + 5)'(count_next);
        res_cnt_next   = cnt_wide[4:0];
        res_empty_next = (count_next == '0);
        m_valid_next   = s_fire || (m_valid_reg && !m_tready);
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_ok_reg    <= res_ok_next;
            res_rd_reg    <= res_rd_next;
            res_cnt_reg   <= res_cnt_next;
            res_empty_reg <= res_empty_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, res_empty_reg, res_cnt_reg, res_rd_reg, res_ok_reg};

    // The count never passes the capacity.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(DEPTH))
        else $error("list count exceeds capacity");

    // An insert into a list with room grows it by one.
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_action == ACT_INSERT && !full)
            |=> count_reg == $past(count_reg) + CntW'(1))
        else $error("insert did not grow the list");

    // A remove that found its value shrinks the list by one.
    a_remove_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_action == ACT_REMOVE && found)
            |=> count_reg == $past(count_reg) - CntW'(1))
        else $error("remove did not shrink the list");

    // A read never succeeds on an empty list.
    a_read_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_action == ACT_READ && count_reg == '0) |=> !res_ok_reg)
        else $error("read succeeded on an empty list");

endmodule
